// ===== hw/rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and status codes for the first-fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // Default pool geometry.
  localparam int unsigned POOL_SIZE  = 2048;
  localparam int unsigned MAX_BLOCKS = 32;

  // Fixed field widths of the request and response channels.
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned START_W = 11;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Request operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

endpackage

// ===== hw/rtl/ffa_if.sv =====
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ffa_pkg::TAG_W-1:0]     tag;
  logic [ffa_pkg::SIZE_W-1:0]    request_size;

  modport source (output valid, operation, tag, request_size, input ready);
  modport sink   (input valid, operation, tag, request_size, output ready);
endinterface

interface ffa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::STAT_W-1:0]    status;
  logic [ffa_pkg::START_W-1:0]   block_start;

  modport source (output valid, status, block_start, input ready);
  modport sink   (input valid, status, block_start, output ready);
endinterface

// ===== hw/rtl/ffa_cell.sv =====
// ----------------------------------------------------------------------------
// ffa_cell
// One cell of the allocator chain: holds one free extent and one block
// entry, folds its contents into the passing search token, and applies the
// final update that the controller broadcasts.
// ----------------------------------------------------------------------------
module ffa_cell #(
  parameter int unsigned POOL_SIZE  = ffa_pkg::POOL_SIZE,
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS,
  parameter int unsigned CELL_IDX   = 0,
  // Width of the packed search token; must equal the bits of tok_t below.
  parameter int unsigned TOK_W      = 8 + ffa_pkg::TAG_W + ffa_pkg::SIZE_W +
                                      6 * $clog2(MAX_BLOCKS) +
                                      4 * $clog2(POOL_SIZE + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic tok_v_i,
  input  logic [TOK_W-1:0] tok_i,
  output logic tok_v_o,
  output logic [TOK_W-1:0] tok_o,
  input  logic upd_en_i,
  input  logic [TOK_W-1:0] upd_tok_i,
  output logic blk_valid_o
);

  localparam int unsigned AW = $clog2(POOL_SIZE + 1);
  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = (AW > ffa_pkg::SIZE_W) ? AW : ffa_pkg::SIZE_W;
  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  typedef struct packed {
    logic                        op;
    logic [ffa_pkg::TAG_W-1:0]   tag;
    logic [ffa_pkg::SIZE_W-1:0]  size;
    logic                        lap;
    logic                        hit;
    logic [IW-1:0]               hit_idx;
    logic [AW-1:0]               s;
    logic [AW-1:0]               blen;
    logic                        pick_v;
    logic [IW-1:0]               pick_idx;
    logic [AW-1:0]               pick_start;
    logic                        slot_v;
    logic [IW-1:0]               slot_idx;
    logic                        bef_v;
    logic [IW-1:0]               bef_idx;
    logic                        aft_v;
    logic [IW-1:0]               aft_idx;
    logic [AW-1:0]               aft_len;
    logic                        nf_v;
    logic [IW-1:0]               nf_idx;
  } tok_t;

  // Free extent and block entry held by this cell.
  logic                        free_v_r;
  logic [AW-1:0]               free_start_r;
  logic [AW-1:0]               free_len_r;
  logic                        blk_v_r;
  logic [ffa_pkg::TAG_W-1:0]   blk_tag_r;
  logic [AW-1:0]               blk_start_r;
  logic [AW-1:0]               blk_len_r;

  logic                        tok_v_r;
  tok_t                        tok_r;
  tok_t                        t_in;
  tok_t                        t_nxt;
  tok_t                        u;
  logic [AW:0]                 free_end;
  logic [AW:0]                 req_end;
  logic [AW-1:0]               size_a;
  logic [AW-1:0]               len_left;
  logic                        fits;

  assign t_in     = tok_t'(tok_i);
  assign u        = tok_t'(upd_tok_i);
  assign free_end = {1'b0, free_start_r} + {1'b0, free_len_r};
  assign req_end  = {1'b0, t_in.s} + {1'b0, t_in.blen};
  assign fits     = CW'(free_len_r) >= CW'(t_in.size);
  assign size_a   = AW'(u.size);
  assign len_left = free_len_r - size_a;

  // Fold this cell's entries into the passing token.
  always_comb begin
    t_nxt = t_in;
    if (!t_in.lap) begin
      if (blk_v_r && blk_tag_r == t_in.tag && !t_in.hit) begin
        t_nxt.hit     = 1'b1;
        t_nxt.hit_idx = MY_IDX;
        t_nxt.s       = blk_start_r;
        t_nxt.blen    = blk_len_r;
      end
      if (!blk_v_r && !t_in.slot_v) begin
        t_nxt.slot_v   = 1'b1;
        t_nxt.slot_idx = MY_IDX;
      end
      if (free_v_r && fits && (!t_in.pick_v || free_start_r < t_in.pick_start)) begin
        t_nxt.pick_v     = 1'b1;
        t_nxt.pick_idx   = MY_IDX;
        t_nxt.pick_start = free_start_r;
      end
      if (!free_v_r && !t_in.nf_v) begin
        t_nxt.nf_v   = 1'b1;
        t_nxt.nf_idx = MY_IDX;
      end
    end else if (free_v_r) begin
      if (free_end == {1'b0, t_in.s}) begin
        t_nxt.bef_v   = 1'b1;
        t_nxt.bef_idx = MY_IDX;
      end else if ({1'b0, free_start_r} == req_end) begin
        t_nxt.aft_v   = 1'b1;
        t_nxt.aft_idx = MY_IDX;
        t_nxt.aft_len = free_len_r;
      end
    end
  end

  // Token stage toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else begin
      tok_v_r <= tok_v_i;
    end
    if (tok_v_i) begin
      tok_r <= t_nxt;
    end
  end

  // Free extent update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_v_r     <= (CELL_IDX == 0);
      free_start_r <= '0;
      free_len_r   <= (CELL_IDX == 0) ? AW'(POOL_SIZE) : '0;
    end else if (upd_en_i) begin
      if (u.op == ffa_pkg::OP_ALLOC) begin
        if (u.pick_idx == MY_IDX) begin
          free_len_r   <= len_left;
          free_v_r     <= (len_left != '0);
          free_start_r <= (len_left == '0) ? '0 : free_start_r + size_a;
        end
      end else if (u.bef_v) begin
        if (u.bef_idx == MY_IDX) begin
          free_len_r <= free_len_r + u.blen + (u.aft_v ? u.aft_len : '0);
        end
        if (u.aft_v && u.aft_idx == MY_IDX) begin
          free_v_r     <= 1'b0;
          free_start_r <= '0;
          free_len_r   <= '0;
        end
      end else if (u.aft_v) begin
        if (u.aft_idx == MY_IDX) begin
          free_start_r <= u.s;
          free_len_r   <= free_len_r + u.blen;
        end
      end else if (u.nf_v && u.nf_idx == MY_IDX) begin
        free_v_r     <= 1'b1;
        free_start_r <= u.s;
        free_len_r   <= u.blen;
      end
    end
  end

  // Block entry update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_v_r <= 1'b0;
    end else if (upd_en_i) begin
      if (u.op == ffa_pkg::OP_ALLOC) begin
        if (u.slot_idx == MY_IDX) begin
          blk_v_r <= 1'b1;
        end
      end else if (u.hit_idx == MY_IDX) begin
        blk_v_r <= 1'b0;
      end
    end
    if (upd_en_i && u.op == ffa_pkg::OP_ALLOC && u.slot_idx == MY_IDX) begin
      blk_tag_r   <= u.tag;
      blk_start_r <= u.pick_start;
      blk_len_r   <= size_a;
    end
  end

  assign tok_v_o     = tok_v_r;
  assign tok_o       = tok_r;
  assign blk_valid_o = blk_v_r;

endmodule

// ===== hw/rtl/first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator
// First-fit pool allocator with coalescing, built as a chain of cells that
// each hold one free extent and one block entry.
// ----------------------------------------------------------------------------
//   Channel   Direction  Transfer carries
//   in_req    sink       operation, tag, request_size
//   out_rsp   source     status, block_start
//
// An allocate's response follows one lap of the search token through the
// cell chain; a free that finds its block needs a second lap of the token
// through the cell chain for its merge search, once the block's extent is known.
// One request is in flight at a time: a new one is taken only after the
// previous response is loaded and the controller is back in idle.
// A response stalled on out_rsp holds the next request's update until taken.
// Synchronous active-low reset leaves one free extent covering the pool.
module first_fit_allocator #(
  parameter int unsigned POOL_SIZE  = ffa_pkg::POOL_SIZE,
  parameter int unsigned MAX_BLOCKS = ffa_pkg::MAX_BLOCKS
) (
  input  logic      clk,
  input  logic      rst_n,
  ffa_req_if.sink   in_req,
  ffa_rsp_if.source out_rsp
);

  localparam int unsigned AW = $clog2(POOL_SIZE + 1);
  localparam int unsigned IW = $clog2(MAX_BLOCKS);

  typedef struct packed {
    logic                        op;
    logic [ffa_pkg::TAG_W-1:0]   tag;
    logic [ffa_pkg::SIZE_W-1:0]  size;
    logic                        lap;
    logic                        hit;
    logic [IW-1:0]               hit_idx;
    logic [AW-1:0]               s;
    logic [AW-1:0]               blen;
    logic                        pick_v;
    logic [IW-1:0]               pick_idx;
    logic [AW-1:0]               pick_start;
    logic                        slot_v;
    logic [IW-1:0]               slot_idx;
    logic                        bef_v;
    logic [IW-1:0]               bef_idx;
    logic                        aft_v;
    logic [IW-1:0]               aft_idx;
    logic [AW-1:0]               aft_len;
    logic                        nf_v;
    logic [IW-1:0]               nf_idx;
  } tok_t;

  localparam int unsigned TOK_W = $bits(tok_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_APPLY
  } state_t;

  state_t                       state_r;
  tok_t                         fin_r;
  logic                         out_valid_r;
  ffa_pkg::status_t             out_status_r;
  logic [ffa_pkg::START_W-1:0]  out_start_r;

  logic [MAX_BLOCKS:0]          chain_v;
  logic [TOK_W-1:0]             chain_tok [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0]        blk_valid;
  tok_t                         head_tok;
  tok_t                         tail_tok;
  logic                         accept;
  logic                         relap;
  logic                         rsp_load;
  logic                         upd_en;
  logic                         upd_ok;
  ffa_pkg::status_t             status_c;
  logic [AW-1:0]                addr_c;

  assign accept       = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign tail_tok     = tok_t'(chain_tok[MAX_BLOCKS]);
  assign relap        = chain_v[MAX_BLOCKS] && !tail_tok.lap &&
                        tail_tok.op == ffa_pkg::OP_FREE && tail_tok.hit;

  // Token entering the head of the chain: a new request or a second lap.
  always_comb begin
    head_tok      = '0;
    head_tok.op   = in_req.operation;
    head_tok.tag  = in_req.tag;
    head_tok.size = in_req.request_size;
    if (relap) begin
      head_tok     = tail_tok;
      head_tok.lap = 1'b1;
    end
  end

  assign chain_v[0]   = accept || relap;
  assign chain_tok[0] = head_tok;

  // Row of cells.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffa_cell #(
      .POOL_SIZE  (POOL_SIZE),
      .MAX_BLOCKS (MAX_BLOCKS),
      .CELL_IDX   (i),
      .TOK_W      (TOK_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_v_i     (chain_v[i]),
      .tok_i       (chain_tok[i]),
      .tok_v_o     (chain_v[i+1]),
      .tok_o       (chain_tok[i+1]),
      .upd_en_i    (upd_en),
      .upd_tok_i   (fin_r),
      .blk_valid_o (blk_valid[i])
    );
  end

  // Outcome of the finished search.
  always_comb begin
    status_c = ffa_pkg::ST_OK;
    addr_c   = fin_r.s;
    if (fin_r.op == ffa_pkg::OP_ALLOC) begin
      addr_c = fin_r.pick_start;
      priority if (fin_r.hit) begin
        status_c = ffa_pkg::ST_DUP;
      end else if (fin_r.size == '0 || !fin_r.pick_v) begin
        status_c = ffa_pkg::ST_NOSPACE;
      end else if (!fin_r.slot_v) begin
        status_c = ffa_pkg::ST_FULL;
      end
    end else if (!fin_r.hit) begin
      status_c = ffa_pkg::ST_NOTFOUND;
    end
  end

  // The response register can take the outcome once it is empty or being read.
  assign rsp_load = (state_r == S_APPLY) && (!out_valid_r || out_rsp.ready);
  assign upd_ok   = (status_c == ffa_pkg::ST_OK);
  assign upd_en   = rsp_load && upd_ok;

  // Controller and response register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (chain_v[MAX_BLOCKS] && !relap) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (rsp_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (chain_v[MAX_BLOCKS]) begin
      fin_r <= tail_tok;
    end
    if (rsp_load) begin
      out_status_r <= status_c;
      out_start_r  <= upd_ok ? ffa_pkg::START_W'(addr_c) : '0;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.block_start = out_start_r;

  // A transfer in always starts a search.
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_RUN))
    else $error("request transfer did not start a search");

  // Error responses carry a zero start address.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ffa_pkg::ST_OK) |-> (out_start_r == '0))
    else $error("error response with nonzero start");

  // A state update is always followed by a pending response.
  a_upd_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> out_valid_r)
    else $error("update without response");

  // No token travels the chain while a new request may be taken.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (chain_v[MAX_BLOCKS:1] == '0))
    else $error("token in chain while idle");

  // A successful free releases exactly the block it found.
  a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_en && fin_r.op == ffa_pkg::OP_FREE) |=>
      ($countones(blk_valid) + 1 == $countones($past(blk_valid))))
    else $error("free did not release one block");

endmodule
